@@ sv/sorted_interval_table_search_core_defines.svh @@
// assertion macros for the interval table port checker
`ifndef SORTED_INTERVAL_TABLE_SEARCH_CORE_DEFINES_SVH
`define SORTED_INTERVAL_TABLE_SEARCH_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define SITS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define SITS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

@@ sv/sits_pkg.sv @@
// types, codes and field layout of the sorted interval table search core
`default_nettype none
package sits_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int TIME_W   = 64;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

  // request tdata layout
  localparam int LOWER_LSB   = 0;
  localparam int UPPER_LSB   = 64;
  localparam int LC_BIT      = 128;
  localparam int UC_BIT      = 129;
  localparam int QUERY_LSB   = 130;
  localparam int IN_DATA_W   = 200;
  localparam int OUT_DATA_W  = 24;

  // one table entry as held in memory, lower bound in the low bits
  typedef struct packed {
    logic              upper_closed;
    logic              lower_closed;
    logic [TIME_W-1:0] upper;
    logic [TIME_W-1:0] lower;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // outcome of comparing a timestamp against one entry
  typedef struct packed {
    logic hit;
    logic go_left;
    logic past_upper;
  } probe_t;

  // result item, found in the low bit
  typedef struct packed {
    logic [POS_W-1:0]    entry_count;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic                found;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage
`default_nettype wire

@@ sv/sits_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module sits_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/sits_probe.sv @@
// compares a query timestamp against one table entry
`default_nettype none
module sits_probe (
  input  wire logic [sits_pkg::TIME_W-1:0] time_i,
  input  wire sits_pkg::entry_t            entry_i,
  output sits_pkg::probe_t                 probe_o
);

  logic gt_lower;
  logic eq_lower;
  logic lt_upper;
  logic eq_upper;

  assign gt_lower = $signed(time_i) > $signed(entry_i.lower);
  assign eq_lower = time_i == entry_i.lower;
  assign lt_upper = $signed(time_i) < $signed(entry_i.upper);
  assign eq_upper = time_i == entry_i.upper;

  assign probe_o.hit = (gt_lower || (eq_lower && entry_i.lower_closed)) &&
                       (lt_upper || (eq_upper && entry_i.upper_closed));
  assign probe_o.go_left    = !gt_lower;
  assign probe_o.past_upper = !lt_upper;

endmodule
`default_nettype wire

@@ sv/sorted_interval_table_search_core.sv @@
// Sorted interval table search core. Keeps up to TABLE_DEPTH intervals in one table memory
// and takes three requests: clear, append (checked against the last stored upper bound)
// and query (binary search for a timestamp). Clear and append finish in the cycle they are
// taken. A query sends its first probe address when it is taken and then makes at most
// ceil(log2(count + 1)) probes; the search is paced by the single read port of the table
// memory, which delivers one entry per cycle while the compare of the previous entry picks
// the next address. Results leave through an output register, so a finished result may
// wait on m_axis_tready while the next request is taken. The table needs no clearing
// after reset: only entries below the fill count are read.
`default_nettype none
module sorted_interval_table_search_core #(
  parameter int TABLE_DEPTH = sits_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lower_time, upper_time, lower_closed, upper_closed, query_time, zero pad
  input  wire logic [sits_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  wire logic [sits_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // found, position, status, entry_count, zero pad
  output logic      [sits_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = sits_pkg::TIME_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] last_up_q, last_up_d;
  logic          last_uc_q, last_uc_d;
  logic [TW-1:0] time_q, time_d;
  logic [CW-1:0] first_q, first_d;
  logic [CW-1:0] bound_q, bound_d;
  logic [IW-1:0] mid_q, mid_d;
  sits_pkg::result_t res_q, res_d;
  sits_pkg::result_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [TW-1:0] in_lower;
  logic [TW-1:0] in_upper;
  logic          in_lc;
  logic          in_uc;
  logic [TW-1:0] in_query;
  logic          accept;
  logic          out_free;
  logic          order_bad;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] mid_first;

  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  sits_pkg::entry_t  ram_wdata;
  sits_pkg::entry_t  ram_rdata;
  sits_pkg::probe_t  probe;

  assign in_lower = s_axis_tdata[sits_pkg::LOWER_LSB +: TW];
  assign in_upper = s_axis_tdata[sits_pkg::UPPER_LSB +: TW];
  assign in_lc    = s_axis_tdata[sits_pkg::LC_BIT];
  assign in_uc    = s_axis_tdata[sits_pkg::UC_BIT];
  assign in_query = s_axis_tdata[sits_pkg::QUERY_LSB +: TW];

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // new lower bound may not start before the last stored upper bound, nor on it when both are closed
  assign order_bad = (count_q != '0) &&
                     (($signed(in_lower) < $signed(last_up_q)) ||
                      ((in_lower == last_up_q) && last_uc_q && in_lc));

  assign count_m1  = count_q - CW'(1);
  assign mid_first = IW'(count_m1 >> 1);

  assign ram_wdata.upper_closed = in_uc;
  assign ram_wdata.lower_closed = in_lc;
  assign ram_wdata.upper        = in_upper;
  assign ram_wdata.lower        = in_lower;

  sits_ram #(
    .WIDTH (sits_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sits_probe u_probe (
    .time_i  (time_q),
    .entry_i (ram_rdata),
    .probe_o (probe)
  );

  always_comb begin
    logic              fin;
    sits_pkg::result_t res_n;
    logic [CW-1:0]     first_n;
    logic [CW-1:0]     bound_n;
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     gap_pos;

    state_d     = state_q;
    count_d     = count_q;
    last_up_d   = last_up_q;
    last_uc_d   = last_uc_q;
    time_d      = time_q;
    first_d     = first_q;
    bound_d     = bound_q;
    mid_d       = mid_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_raddr   = mid_first;
    fin         = 1'b0;
    res_n       = '0;
    first_n     = first_q;
    bound_n     = bound_q;
    mid_sum     = '0;
    gap_pos     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            sits_pkg::FUNC_CLEAR: begin
              count_d = '0;
              fin     = 1'b1;
            end
            sits_pkg::FUNC_APPEND: begin
              fin = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                res_n.status = sits_pkg::STATUS_FULL;
              end else if (order_bad) begin
                res_n.status = sits_pkg::STATUS_ORDER;
              end else begin
                ram_we    = 1'b1;
                count_d   = count_q + CW'(1);
                last_up_d = in_upper;
                last_uc_d = in_uc;
              end
            end
            sits_pkg::FUNC_QUERY: begin
              if (count_q == '0) begin
                fin          = 1'b1;
                res_n.status = sits_pkg::STATUS_EMPTY;
              end else begin
                // first probe address goes to the memory in this cycle
                time_d  = in_query;
                first_d = '0;
                bound_d = count_q;
                mid_d   = mid_first;
                state_d = ST_SEARCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
          res_n.entry_count = sits_pkg::POS_W'(count_d);
        end
      end
      ST_SEARCH: begin
        res_n.entry_count = sits_pkg::POS_W'(count_q);
        if (probe.hit) begin
          fin            = 1'b1;
          res_n.found    = 1'b1;
          res_n.position = sits_pkg::POS_W'(mid_q);
        end else begin
          if (probe.go_left) begin
            bound_n = CW'(mid_q);
          end else begin
            first_n = CW'(mid_q) + CW'(1);
          end
          // search range is first_n up to but not including bound_n
          mid_sum   = {1'b0, first_n} + {1'b0, bound_n} - (CW + 1)'(1);
          ram_raddr = mid_sum[IW:1];
          if (first_n >= bound_n) begin
            fin            = 1'b1;
            gap_pos        = CW'(mid_q) + CW'(probe.past_upper);
            res_n.position = sits_pkg::POS_W'(gap_pos);
          end else begin
            first_d = first_n;
            bound_d = bound_n;
            mid_d   = mid_sum[IW:1];
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_d       = res_n;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        res_d   = res_n;
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_up_q <= last_up_d;
    last_uc_q <= last_uc_d;
    time_q    <= time_d;
    first_q   <= first_d;
    bound_q   <= bound_d;
    mid_q     <= mid_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sits_pkg::OUT_DATA_W'(out_q);

endmodule
`default_nettype wire

@@ sv/sits_checker.sv @@
// port-level checks on the interval table search core, bound to the top level
`default_nettype none
`include "sorted_interval_table_search_core_defines.svh"
module sits_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [sits_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  sits_pkg::result_t res;

  assign res = m_axis_tdata[sits_pkg::RESULT_W-1:0];

  // a stalled result keeps its value
  `SITS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // a hit is always a successful query
  `SITS_ASSERT(a_found_ok, m_axis_tvalid && res.found |-> res.status == sits_pkg::STATUS_OK, "found with error status")

  // any error result carries no position
  `SITS_ASSERT(a_err_pos, m_axis_tvalid && res.status != sits_pkg::STATUS_OK |-> !res.found && res.position == '0, "error result with position")

  // an empty-table error reports an empty table
  `SITS_ASSERT_CLK(a_empty_cnt, clk_i, rst_ni, m_axis_tvalid && res.status == sits_pkg::STATUS_EMPTY |-> res.entry_count == '0, "empty error with entries")

endmodule

bind sorted_interval_table_search_core sits_checker u_sits_checker (.*);
`default_nettype wire

@@ dv/sorted_interval_table_search_core_checker.sv @@
// result checker for the sorted interval table search core: predicts every result and compares
module sorted_interval_table_search_core_checker #(
  parameter int TABLE_DEPTH = sits_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // lower_time, upper_time, lower_closed, upper_closed, query_time, zero pad
  input  logic [sits_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [sits_pkg::FUNC_W-1:0]     s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // found, position, status, entry_count, zero pad
  input  logic [sits_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sits_pkg::*;

  entry_t  slot_q [TABLE_DEPTH];
  int      fill;
  result_t awaited_q [$];
  int      mismatches;
  int      outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fill        = 0;
  end

  function automatic bit covers(input entry_t e, input logic signed [TIME_W-1:0] t);
    bit above;
    bit below;
    above = (t > $signed(e.lower)) || (t == $signed(e.lower) && e.lower_closed);
    below = (t < $signed(e.upper)) || (t == $signed(e.upper) && e.upper_closed);
    return above && below;
  endfunction

  // updates the table copy and returns the result the request must give
  function automatic result_t apply_request(input logic [FUNC_W-1:0] func,
                                            input logic [IN_DATA_W-1:0] data);
    result_t                  r;
    logic signed [TIME_W-1:0] lo_t;
    logic signed [TIME_W-1:0] hi_t;
    logic signed [TIME_W-1:0] q_t;
    logic                     lc;
    logic                     uc;
    int                       first;
    int                       last;
    int                       mid;
    bit                       hit;
    r    = '0;
    lo_t = data[LOWER_LSB +: TIME_W];
    hi_t = data[UPPER_LSB +: TIME_W];
    q_t  = data[QUERY_LSB +: TIME_W];
    lc   = data[LC_BIT];
    uc   = data[UC_BIT];
    case (func)
      FUNC_CLEAR: begin
        fill = 0;
      end
      FUNC_APPEND: begin
        if (fill >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else if (fill > 0 && (lo_t < $signed(slot_q[fill-1].upper) ||
                     (lo_t == $signed(slot_q[fill-1].upper) &&
                      slot_q[fill-1].upper_closed && lc))) begin
          r.status = STATUS_ORDER;
        end else begin
          slot_q[fill].lower        = lo_t;
          slot_q[fill].upper        = hi_t;
          slot_q[fill].lower_closed = lc;
          slot_q[fill].upper_closed = uc;
          fill++;
        end
      end
      FUNC_QUERY: begin
        if (fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          first = 0;
          last  = fill - 1;
          mid   = 0;
          hit   = 1'b0;
          while (!hit && first <= last) begin
            mid = (first + last) / 2;
            if (covers(slot_q[mid], q_t)) hit = 1'b1;
            else if (q_t <= $signed(slot_q[mid].lower)) last = mid - 1;
            else first = mid + 1;
          end
          r.found = hit;
          // a miss reports the gap next to the last probed interval
          if (!hit && q_t >= $signed(slot_q[mid].upper)) r.position = POS_W'(mid + 1);
          else r.position = POS_W'(mid);
        end
      end
      default: begin
      end
    endcase
    r.entry_count = POS_W'(fill);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      fill = 0;
      awaited_q.delete();
      outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (awaited_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, found %0d position %0d status %0d count %0d",
                   $time, got.found, got.position, got.status, got.entry_count);
        end else begin
          want = awaited_q.pop_front();
          check_field("found", want.found, got.found);
          check_field("position", want.position, got.position);
          check_field("status", want.status, got.status);
          check_field("entry_count", want.entry_count, got.entry_count);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
      outstanding = awaited_q.size();
    end
  end

endmodule

@@ dv/sorted_interval_table_search_core_tb.sv @@
// testbench top for the sorted interval table search core: clock, reset, stimulus and verdict
module sorted_interval_table_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sits_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int REQUESTS    = 1000;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [FUNC_W-1:0]        FUNC_UNUSED = 2'd3;
  localparam logic signed [TIME_W-1:0] MIN_T = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] MAX_T = {1'b0, {(TIME_W-1){1'b1}}};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = FUNC_CLEAR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    pending;

  // intervals the table should hold, only used to shape well-formed requests
  logic signed [TIME_W-1:0] kept_lo [DEPTH];
  logic signed [TIME_W-1:0] kept_hi [DEPTH];
  int                       kept_n       = 0;
  logic                     kept_tail_uc = 1'b0;
  int                       sent         = 0;
  bit                       no_gaps      = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_interval_table_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  sorted_interval_table_search_core_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] clamp(input logic [TIME_W-1:0] v,
                                              input logic [TIME_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [TIME_W-1:0] room_above(input logic signed [TIME_W-1:0] v);
    return MAX_T - v;
  endfunction

  function automatic logic [TIME_W-1:0] room_below(input logic signed [TIME_W-1:0] v);
    return v - MIN_T;
  endfunction

  task automatic push_request(input logic [FUNC_W-1:0] fn,
                              input logic signed [TIME_W-1:0] lo,
                              input logic signed [TIME_W-1:0] hi,
                              input logic lc, input logic uc,
                              input logic signed [TIME_W-1:0] qt);
    int                   gap;
    logic [IN_DATA_W-1:0] word;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[LOWER_LSB +: TIME_W] = lo;
    word[UPPER_LSB +: TIME_W] = hi;
    word[LC_BIT]              = lc;
    word[UC_BIT]              = uc;
    word[QUERY_LSB +: TIME_W] = qt;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (fn != FUNC_UNUSED) sent++;
  endtask

  // holds off the next request until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic do_clear();
    push_request(FUNC_CLEAR, rand64(), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), rand64());
    kept_n = 0;
  endtask

  task automatic send_unused();
    push_request(FUNC_UNUSED, rand64(), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), rand64());
  endtask

  // append that keeps the table in order, or hits the full table
  task automatic grow_table(input int shift_lo, input bit wide_start);
    logic signed [TIME_W-1:0] lo;
    logic signed [TIME_W-1:0] hi;
    logic                     lc;
    logic                     uc;
    lc = 1'($urandom_range(0, 1));
    uc = 1'($urandom_range(0, 1));
    if (kept_n == 0) begin
      lo = wide_start ? rand64() : MIN_T + (rand64() >> $urandom_range(2, 63));
    end else begin
      lo = kept_hi[kept_n-1];
      if ($urandom_range(0, 3) != 0)
        lo = lo + clamp(rand64() >> $urandom_range(shift_lo, 63), room_above(lo));
      // touching bounds may not both be inclusive
      if (lo == kept_hi[kept_n-1] && kept_tail_uc) lc = 1'b0;
    end
    // an upper bound below the lower one is accepted as is
    if ($urandom_range(0, 19) == 0)
      hi = lo - clamp(rand64() >> $urandom_range(shift_lo, 63), room_below(lo));
    else
      hi = lo + clamp(rand64() >> $urandom_range(shift_lo, 63), room_above(lo));
    push_request(FUNC_APPEND, lo, hi, lc, uc, rand64());
    if (kept_n < DEPTH) begin
      kept_lo[kept_n] = lo;
      kept_hi[kept_n] = hi;
      kept_tail_uc    = uc;
      kept_n++;
    end
  endtask

  task automatic probe_table();
    int                       k;
    logic signed [TIME_W-1:0] t;
    if (kept_n == 0) begin
      t = rand64();
    end else begin
      k = $urandom_range(0, kept_n - 1);
      case ($urandom_range(0, 7))
        0:       t = kept_lo[k];
        1:       t = kept_hi[k];
        2:       t = kept_lo[k] - 64'sd1;
        3:       t = kept_hi[k] + 64'sd1;
        4:       t = kept_lo[k] + ((kept_hi[k] - kept_lo[k]) >>> 1);
        5:       t = ($urandom_range(0, 1) != 0) ? MIN_T : MAX_T;
        6:       t = kept_hi[kept_n-1] + 64'sd1;
        default: t = rand64();
      endcase
    end
    push_request(FUNC_QUERY, rand64(), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), t);
  endtask

  // append that must be refused, for its order unless the table is full; else a query
  task automatic break_order(input int shift_lo);
    logic signed [TIME_W-1:0] tail;
    logic signed [TIME_W-1:0] lo;
    if (kept_n == 0) begin
      probe_table();
    end else begin
      tail = kept_hi[kept_n-1];
      if (kept_tail_uc && (tail == MIN_T || $urandom_range(0, 1) == 0)) begin
        push_request(FUNC_APPEND, tail, rand64(), 1'b1, 1'($urandom_range(0, 1)), rand64());
      end else if (tail == MIN_T) begin
        probe_table();
      end else begin
        lo = tail - 64'sd1 -
             clamp(rand64() >> $urandom_range(shift_lo, 63), room_below(tail) - 64'd1);
        push_request(FUNC_APPEND, lo, rand64(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), rand64());
      end
    end
  endtask

  initial begin : result_sink
    int run;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      run = pick_gap();
      if (run > 0) begin
        m_axis_tready <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int episode;
    int target;
    int grown;
    int r;
    bit big;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused code, order and equal-bound rules, inverted bounds, extremes
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, 64'sd0);
    send_unused();
    push_request(FUNC_APPEND, MIN_T, MIN_T, 1'b1, 1'b1, rand64());
    push_request(FUNC_APPEND, MIN_T, 64'sd5, 1'b1, 1'b0, rand64());
    push_request(FUNC_APPEND, MIN_T, -64'sd1000, 1'b0, 1'b0, rand64());
    push_request(FUNC_APPEND, -64'sd2000, 64'sd7, 1'b1, 1'b1, rand64());
    push_request(FUNC_APPEND, -64'sd1000, 64'sd0, 1'b1, 1'b0, rand64());
    push_request(FUNC_APPEND, 64'sd10, 64'sd5, 1'b0, 1'b1, rand64());
    push_request(FUNC_APPEND, 64'sd100, MAX_T, 1'b1, 1'b1, rand64());
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b1, 1'b1, MIN_T);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b1, 1'b1, MAX_T);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, -64'sd1000);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, 64'sd0);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, 64'sd7);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, 64'sd50);
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, 64'sd99);
    send_unused();
    push_request(FUNC_APPEND, MAX_T, MAX_T, 1'b0, 1'b0, rand64());
    push_request(FUNC_APPEND, MAX_T, MIN_T, 1'b1, 1'b1, rand64());
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, MAX_T);
    do_clear();
    push_request(FUNC_QUERY, rand64(), rand64(), 1'b0, 1'b0, rand64());
    push_request(FUNC_APPEND, rand64(), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), rand64());
    do_clear();
    wait_drained();

    // episodes of well-formed table builds with queries, broken appends and noise
    episode = 0;
    while (sent < REQUESTS) begin
      big     = (episode == 1) || (episode == 4);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (episode == 2 || $urandom_range(0, 2) == 0) wait_drained();
      do_clear();
      target = big ? DEPTH + int'($urandom_range(2, 6)) : int'($urandom_range(1, 24));
      grown  = 0;
      while (grown < target) begin
        r = $urandom_range(0, 99);
        if (r < (big ? 80 : 55)) begin
          grow_table(big ? 10 : 4, bit'(!big && $urandom_range(0, 1) != 0));
          grown++;
        end else if (r < 88) begin
          probe_table();
        end else if (r < 96) begin
          break_order(big ? 10 : 4);
        end else begin
          send_unused();
        end
      end
      repeat (big ? 40 : int'($urandom_range(4, 20))) probe_table();
      episode++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sorted_interval_table_search_core.f @@
+incdir+sv
sv/sits_pkg.sv
sv/sits_ram.sv
sv/sits_probe.sv
sv/sorted_interval_table_search_core.sv
sv/sits_checker.sv
dv/sorted_interval_table_search_core_checker.sv
dv/sorted_interval_table_search_core_tb.sv
